[rtl/kfs_pkg.sv]
// Shared types, codes and helpers for the three-state Kalman filter.
// Used by kfs_ctrl, kfs_dp, kfs_div and scalar_kalman_filter_3state.
package kfs_pkg;

    localparam int DATA_W    = 32;
    localparam int COEF_W    = 16;
    localparam int COEF_BITS = 12;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int R_W       = 40;
    localparam int ACC_W     = 66;
    localparam int SAT_W     = 68;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRANS0 = 3'd0,
        CFG_TRANS1 = 3'd1,
        CFG_TRANS2 = 3'd2,
        CFG_QDIAG  = 3'd3,
        CFG_QOFF   = 3'd4,
        CFG_OBS    = 3'd5,
        CFG_MNOISE = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_KC, PH_R, PH_DIV, PH_ACC, PH_XP, PH_DP, PH_X,
        PH_FV, PH_CK, PH_PC, PH_T, PH_P, PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE, S_MAC, S_DRAIN, S_DIV_GO, S_DIV_WAIT, S_ACC, S_FINISH
    } ctl_state_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] i;
        logic [1:0] j;
        logic [1:0] k;
        logic       mul;
        logic       first;
        logic       last;
        logic       div_start;
        logic       load_in;
        logic       acc_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        phase_t     phase;
        logic [1:0] i;
        logic [1:0] j;
    } mac_tag_t;

    typedef struct packed {
        logic                     flag;
        logic signed [DATA_W-1:0] val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
        sat_t s;
        if (v > 68'sd2147483647) begin
            s.flag = 1'b1;
            s.val  = 32'sh7FFFFFFF;
        end else if (v < -68'sd2147483648) begin
            s.flag = 1'b1;
            s.val  = 32'sh80000000;
        end else begin
            s.flag = 1'b0;
            s.val  = v[DATA_W-1:0];
        end
        return s;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef(input logic [CFG_W-1:0] r,
                                                      input logic [1:0] j);
        logic signed [COEF_W-1:0] c;
        case (j)
            2'd0:    c = r[15:0];
            2'd1:    c = r[31:16];
            default: c = r[47:32];
        endcase
        return c;
    endfunction

    function automatic logic [3:0] idx3(input logic [1:0] row, input logic [1:0] col);
        return {2'b00, row} * 4'd3 + {2'b00, col};
    endfunction

    // Loop bounds (last index) of each multiply-accumulate phase.
    function automatic logic [1:0] imax(input phase_t ph);
        logic [1:0] m;
        case (ph)
            PH_KC, PH_XP, PH_X, PH_PC, PH_T, PH_P: m = 2'd2;
            default:                               m = 2'd0;
        endcase
        return m;
    endfunction

    function automatic logic [1:0] jmax(input phase_t ph);
        logic [1:0] m;
        case (ph)
            PH_CK, PH_PC, PH_T, PH_P: m = 2'd2;
            default:                  m = 2'd0;
        endcase
        return m;
    endfunction

    function automatic logic [1:0] kmax(input phase_t ph);
        logic [1:0] m;
        case (ph)
            PH_X, PH_PC: m = 2'd0;
            default:     m = 2'd2;
        endcase
        return m;
    endfunction

    function automatic phase_t next_phase(input phase_t ph);
        phase_t n;
        case (ph)
            PH_KC:   n = PH_R;
            PH_R:    n = PH_DIV;
            PH_DIV:  n = PH_ACC;
            PH_ACC:  n = PH_XP;
            PH_XP:   n = PH_DP;
            PH_DP:   n = PH_X;
            PH_X:    n = PH_FV;
            PH_FV:   n = PH_CK;
            PH_CK:   n = PH_PC;
            PH_PC:   n = PH_T;
            PH_T:    n = PH_P;
            default: n = PH_DONE;
        endcase
        return n;
    endfunction

endpackage

[rtl/kfs_div.sv]
// Gain divider: (num << FRAC_BITS) / den, truncated toward zero, 32-bit saturated.
// Restoring, one quotient bit per cycle. Depends on kfs_pkg.
module kfs_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [kfs_pkg::DATA_W-1:0] num,
    input  logic [kfs_pkg::R_W-1:0]           den,
    output logic                              done,
    output logic signed [kfs_pkg::DATA_W-1:0] quot,
    output logic                              quot_sat
);
    localparam int NW   = kfs_pkg::DATA_W + 1 + FRAC_BITS;
    localparam int HI_W = NW - kfs_pkg::DATA_W;
    localparam int RM_W = kfs_pkg::R_W + 1;

    logic [RM_W-1:0]              rem_reg;
    logic [kfs_pkg::DATA_W-1:0]   lo_reg;
    logic [kfs_pkg::DATA_W-1:0]   q_reg;
    logic [kfs_pkg::R_W-1:0]      den_reg;
    logic [4:0]                   cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic                         neg_reg;
    logic                         ovf_reg;

    logic signed [kfs_pkg::DATA_W:0] num_x;
    logic [kfs_pkg::DATA_W:0]        mag;
    logic [NW-1:0]                   mag_sh;
    logic [HI_W-1:0]                 hi;
    logic [RM_W-1:0]                 shifted;
    logic                            ge;
    logic signed [kfs_pkg::DATA_W+1:0] qv;
    kfs_pkg::sat_t                   qs;

    always_comb
    begin
        num_x   = (kfs_pkg::DATA_W+1)'(num);
        mag     = num_x[kfs_pkg::DATA_W] ? $unsigned(-num_x) : $unsigned(num_x);
        mag_sh  = NW'(mag) << FRAC_BITS;
        hi      = mag_sh[NW-1:kfs_pkg::DATA_W];
        shifted = {rem_reg[RM_W-2:0], lo_reg[kfs_pkg::DATA_W-1]};
        ge      = shifted >= {1'b0, den_reg};
        qv      = $signed({2'b00, q_reg});
        if (neg_reg)
        begin
            qv = -qv;
        end
        qs = kfs_pkg::sat32(kfs_pkg::SAT_W'(qv));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= RM_W'(hi);
            lo_reg  <= mag_sh[kfs_pkg::DATA_W-1:0];
            den_reg <= den;
            neg_reg <= num_x[kfs_pkg::DATA_W];
            ovf_reg <= RM_W'(hi) >= {1'b0, den};
            q_reg   <= '0;
        end else if (busy_reg)
        begin
            rem_reg <= ge ? shifted - {1'b0, den_reg} : shifted;
            lo_reg  <= {lo_reg[kfs_pkg::DATA_W-2:0], 1'b0};
            q_reg   <= {q_reg[kfs_pkg::DATA_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quot     = ovf_reg ? (neg_reg ? 32'sh80000000 : 32'sh7FFFFFFF) : qs.val;
    assign quot_sat = ovf_reg | qs.flag;

endmodule

[rtl/kfs_ctrl.sv]
// Step sequencer: walks the filter phases and their index loops, drives the datapath.
// Depends on kfs_pkg.
module kfs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  kfs_pkg::stat_t stat,
    output kfs_pkg::cmd_t  cmd
);
    kfs_pkg::ctl_state_t state_reg, state_next;
    kfs_pkg::phase_t     phase_reg, phase_next;
    logic [1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic       dcnt_reg, dcnt_next;
    logic       out_valid_reg, out_valid_next;
    kfs_pkg::phase_t np;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kfs_pkg::S_IDLE;
            phase_reg     <= kfs_pkg::PH_KC;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            dcnt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        dcnt_next     = dcnt_reg;
        in_ready      = 1'b0;
        np            = kfs_pkg::next_phase(phase_reg);
        cmd           = '0;
        cmd.phase     = phase_reg;
        cmd.i         = i_reg;
        cmd.j         = j_reg;
        cmd.k         = k_reg;
        case (state_reg)
            kfs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    phase_next  = kfs_pkg::PH_KC;
                    i_next      = '0;
                    j_next      = '0;
                    k_next      = '0;
                    state_next  = kfs_pkg::S_MAC;
                end
            end
            kfs_pkg::S_MAC:
            begin
                cmd.mul   = 1'b1;
                cmd.first = (k_reg == 2'd0);
                cmd.last  = (k_reg == kfs_pkg::kmax(phase_reg));
                if (k_reg == kfs_pkg::kmax(phase_reg))
                begin
                    k_next = '0;
                    if (j_reg == kfs_pkg::jmax(phase_reg))
                    begin
                        j_next = '0;
                        if (i_reg == kfs_pkg::imax(phase_reg))
                        begin
                            i_next     = '0;
                            dcnt_next  = 1'b0;
                            state_next = kfs_pkg::S_DRAIN;
                        end else begin
                            i_next = i_reg + 2'd1;
                        end
                    end else begin
                        j_next = j_reg + 2'd1;
                    end
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end
            kfs_pkg::S_DRAIN:
            begin
                // wait here until the last sum reaches its register
                dcnt_next = 1'b1;
                if (dcnt_reg)
                begin
                    phase_next = np;
                    if (np == kfs_pkg::PH_DIV)
                    begin
                        state_next = kfs_pkg::S_DIV_GO;
                    end else if (np == kfs_pkg::PH_DONE)
                    begin
                        state_next = kfs_pkg::S_FINISH;
                    end else begin
                        state_next = kfs_pkg::S_MAC;
                    end
                end
            end
            kfs_pkg::S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = kfs_pkg::S_DIV_WAIT;
            end
            kfs_pkg::S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    if (i_reg == 2'd2)
                    begin
                        i_next     = '0;
                        phase_next = kfs_pkg::PH_ACC;
                        state_next = kfs_pkg::S_ACC;
                    end else begin
                        i_next     = i_reg + 2'd1;
                        state_next = kfs_pkg::S_DIV_GO;
                    end
                end
            end
            kfs_pkg::S_ACC:
            begin
                cmd.acc_step = 1'b1;
                phase_next   = kfs_pkg::PH_XP;
                state_next   = kfs_pkg::S_MAC;
            end
            kfs_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = kfs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kfs_pkg::S_IDLE;
            end
        endcase
        out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/kfs_dp.sv]
// Filter datapath: configuration, state, one shared multiply-accumulate, gain divider.
// Depends on kfs_pkg and kfs_div.
module kfs_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [kfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kfs_pkg::CFG_W-1:0]         cfg_data,
    input  logic signed [kfs_pkg::DATA_W-1:0] in_meas,
    input  logic signed [kfs_pkg::DATA_W-1:0] in_accel,
    input  kfs_pkg::cmd_t                     cmd,
    output kfs_pkg::stat_t                    stat,
    output logic signed [kfs_pkg::DATA_W-1:0] out_fv,
    output logic signed [kfs_pkg::DATA_W-1:0] out_x0,
    output logic signed [kfs_pkg::DATA_W-1:0] out_x1,
    output logic signed [kfs_pkg::DATA_W-1:0] out_x2,
    output logic                              out_sat
);
    localparam int DW   = kfs_pkg::DATA_W;
    localparam int AW   = kfs_pkg::ACC_W;
    localparam int SW   = kfs_pkg::SAT_W;
    localparam int QSHL = (FRAC_BITS >= kfs_pkg::COEF_BITS) ? FRAC_BITS - kfs_pkg::COEF_BITS : 0;
    localparam int QSHR = (FRAC_BITS < kfs_pkg::COEF_BITS) ? kfs_pkg::COEF_BITS - FRAC_BITS : 0;
    localparam logic signed [DW-1:0] QHALF = (QSHR > 0) ? DW'(1) << (QSHR - 1) : '0;
    localparam logic signed [AW-1:0] HALF_C = AW'(1) << (kfs_pkg::COEF_BITS - 1);
    localparam logic signed [AW-1:0] HALF_F = AW'(1) << (FRAC_BITS - 1);

    logic [kfs_pkg::CFG_W-1:0] f_row_reg [3];
    logic [kfs_pkg::CFG_W-1:0] qdiag_reg, qoff_reg, obs_reg;
    logic [DW-1:0]             mnoise_reg;

    logic signed [DW-1:0] meas_reg, accel_reg;
    logic signed [DW-1:0] x_reg [3];
    logic signed [DW-1:0] p_reg [9];
    logic signed [DW-1:0] kc_reg [3];
    logic signed [DW-1:0] g_reg [3];
    logic signed [DW-1:0] xp_reg [3];
    logic signed [DW-1:0] ck_reg [3];
    logic signed [DW-1:0] pc_reg [9];
    logic signed [DW-1:0] t_reg [9];
    logic signed [DW-1:0] alpha_reg, fv_reg;
    logic signed [kfs_pkg::R_W-1:0] r_reg;
    logic                 sat_reg;
    logic [1:0]           div_idx_reg;

    logic signed [2*DW-1:0] prod_reg;
    logic signed [DW-1:0]   aux1_reg, aux2_reg;
    kfs_pkg::mac_tag_t      tag1_reg, tag2_reg;
    logic signed [AW-1:0]   acc_reg;

    logic signed [DW-1:0] op_a, op_b, aux;
    logic signed [kfs_pkg::COEF_W-1:0] qc;
    logic signed [DW-1:0] qd;
    logic signed [AW-1:0] rnd_c, rnd_f;
    kfs_pkg::sat_t        wb, dp_s, al_s, x2_s;
    logic                 wb_en, wb_flag;
    logic [3:0]           wb_ij;
    logic signed [kfs_pkg::R_W-1:0] r_new;

    logic                 div_done, div_sat;
    logic signed [DW-1:0] div_q;

    function automatic logic signed [DW-1:0] cx(input logic signed [kfs_pkg::COEF_W-1:0] c);
        return DW'(c);
    endfunction

    kfs_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (kc_reg[cmd.i]),
        .den      ($unsigned(r_reg)),
        .done     (div_done),
        .quot     (div_q),
        .quot_sat (div_sat)
    );

    assign stat.div_done = div_done;

    // operand and addend selection for the multiply stage
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        aux  = '0;
        if (cmd.i == cmd.j)
        begin
            qc = kfs_pkg::coef(qdiag_reg, cmd.i);
        end else begin
            qc = kfs_pkg::coef(qoff_reg, cmd.i + cmd.j - 2'd1);
        end
        if (FRAC_BITS >= kfs_pkg::COEF_BITS)
        begin
            qd = cx(qc) <<< QSHL;
        end else begin
            qd = (cx(qc) + QHALF) >>> QSHR;
        end
        case (cmd.phase)
            kfs_pkg::PH_KC:
            begin
                op_a = p_reg[kfs_pkg::idx3(cmd.i, cmd.k)];
                op_b = cx(kfs_pkg::coef(obs_reg, cmd.k));
            end
            kfs_pkg::PH_R:
            begin
                op_a = kc_reg[cmd.k];
                op_b = cx(kfs_pkg::coef(obs_reg, cmd.k));
            end
            kfs_pkg::PH_XP:
            begin
                op_a = x_reg[cmd.k];
                op_b = cx(kfs_pkg::coef(f_row_reg[cmd.i], cmd.k));
            end
            kfs_pkg::PH_DP:
            begin
                op_a = xp_reg[cmd.k];
                op_b = cx(kfs_pkg::coef(obs_reg, cmd.k));
                aux  = meas_reg;
            end
            kfs_pkg::PH_X:
            begin
                op_a = g_reg[cmd.i];
                op_b = alpha_reg;
                aux  = xp_reg[cmd.i];
            end
            kfs_pkg::PH_FV:
            begin
                op_a = x_reg[cmd.k];
                op_b = cx(kfs_pkg::coef(obs_reg, cmd.k));
            end
            kfs_pkg::PH_CK:
            begin
                op_a = p_reg[kfs_pkg::idx3(cmd.k, cmd.j)];
                op_b = cx(kfs_pkg::coef(obs_reg, cmd.k));
            end
            kfs_pkg::PH_PC:
            begin
                op_a = g_reg[cmd.i];
                op_b = ck_reg[cmd.j];
                aux  = p_reg[kfs_pkg::idx3(cmd.i, cmd.j)];
            end
            kfs_pkg::PH_T:
            begin
                op_a = pc_reg[kfs_pkg::idx3(cmd.k, cmd.j)];
                op_b = cx(kfs_pkg::coef(f_row_reg[cmd.i], cmd.k));
            end
            kfs_pkg::PH_P:
            begin
                op_a = t_reg[kfs_pkg::idx3(cmd.i, cmd.k)];
                op_b = cx(kfs_pkg::coef(f_row_reg[cmd.j], cmd.k));
                aux  = qd;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    // multiply, then accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end else begin
            tag1_reg.valid <= cmd.mul;
            tag1_reg.first <= cmd.first;
            tag1_reg.last  <= cmd.last;
            tag1_reg.phase <= cmd.phase;
            tag1_reg.i     <= cmd.i;
            tag1_reg.j     <= cmd.j;
            tag2_reg       <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        aux1_reg <= aux;
        aux2_reg <= aux1_reg;
        if (tag1_reg.valid)
        begin
            acc_reg <= tag1_reg.first ? AW'(prod_reg) : acc_reg + AW'(prod_reg);
        end
    end

    // round, saturate and pick the write-back value
    always_comb
    begin
        rnd_c   = (acc_reg + HALF_C) >>> kfs_pkg::COEF_BITS;
        rnd_f   = (acc_reg + HALF_F) >>> FRAC_BITS;
        wb_en   = tag2_reg.valid && tag2_reg.last;
        wb_ij   = kfs_pkg::idx3(tag2_reg.i, tag2_reg.j);
        r_new   = kfs_pkg::R_W'(rnd_c) + kfs_pkg::R_W'($signed({1'b0, mnoise_reg}));
        dp_s    = kfs_pkg::sat32(SW'(rnd_c));
        al_s    = kfs_pkg::sat32(SW'(aux2_reg) - SW'(dp_s.val));
        x2_s    = kfs_pkg::sat32(SW'(x_reg[2]) + SW'(accel_reg));
        case (tag2_reg.phase)
            kfs_pkg::PH_X:  wb = kfs_pkg::sat32(SW'(aux2_reg) + SW'(rnd_f));
            kfs_pkg::PH_PC: wb = kfs_pkg::sat32(SW'(aux2_reg) - SW'(rnd_f));
            kfs_pkg::PH_P:  wb = kfs_pkg::sat32(SW'(rnd_c) + SW'(aux2_reg));
            kfs_pkg::PH_DP: wb = al_s;
            default:        wb = dp_s;
        endcase
        wb_flag = 1'b0;
        if (wb_en && tag2_reg.phase != kfs_pkg::PH_R)
        begin
            wb_flag = wb.flag || (tag2_reg.phase == kfs_pkg::PH_DP && dp_s.flag);
        end
    end

    // configuration and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < 3; n++)
            begin
                f_row_reg[n] <= '0;
                x_reg[n]     <= '0;
            end
            qdiag_reg  <= '0;
            qoff_reg   <= '0;
            obs_reg    <= '0;
            mnoise_reg <= DW'(1) << FRAC_BITS;
            for (int n = 0; n < 9; n++)
            begin
                p_reg[n] <= (n == 0 || n == 4 || n == 8) ? DW'(1) << FRAC_BITS : '0;
            end
            sat_reg <= 1'b0;
        end else begin
            if (cfg_we)
            begin
                case (cfg_index)
                    kfs_pkg::CFG_TRANS0: f_row_reg[0] <= cfg_data;
                    kfs_pkg::CFG_TRANS1: f_row_reg[1] <= cfg_data;
                    kfs_pkg::CFG_TRANS2: f_row_reg[2] <= cfg_data;
                    kfs_pkg::CFG_QDIAG:  qdiag_reg    <= cfg_data;
                    kfs_pkg::CFG_QOFF:   qoff_reg     <= cfg_data;
                    kfs_pkg::CFG_OBS:    obs_reg      <= cfg_data;
                    kfs_pkg::CFG_MNOISE: mnoise_reg   <= cfg_data[DW-1:0];
                    default:             ;
                endcase
            end
            if (cmd.load_in)
            begin
                sat_reg <= 1'b0;
            end else begin
                sat_reg <= sat_reg | wb_flag | (cmd.acc_step & x2_s.flag)
                           | (div_done & (div_sat | (r_reg <= 0)));
            end
            if (cmd.acc_step)
            begin
                x_reg[2] <= x2_s.val;
            end
            if (wb_en && tag2_reg.phase == kfs_pkg::PH_X)
            begin
                x_reg[tag2_reg.i] <= wb.val;
            end
            if (wb_en && tag2_reg.phase == kfs_pkg::PH_P)
            begin
                p_reg[wb_ij] <= wb.val;
            end
        end
    end

    // per-step scratch values
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            meas_reg  <= in_meas;
            accel_reg <= in_accel;
        end
        if (cmd.div_start)
        begin
            div_idx_reg <= cmd.i;
        end
        if (div_done)
        begin
            g_reg[div_idx_reg] <= (r_reg <= 0) ? '0 : div_q;
        end
        if (wb_en)
        begin
            case (tag2_reg.phase)
                kfs_pkg::PH_KC: kc_reg[tag2_reg.i] <= wb.val;
                kfs_pkg::PH_R:  r_reg              <= r_new;
                kfs_pkg::PH_XP: xp_reg[tag2_reg.i] <= wb.val;
                kfs_pkg::PH_DP: alpha_reg          <= wb.val;
                kfs_pkg::PH_FV: fv_reg             <= wb.val;
                kfs_pkg::PH_CK: ck_reg[tag2_reg.j] <= wb.val;
                kfs_pkg::PH_PC: pc_reg[wb_ij]      <= wb.val;
                kfs_pkg::PH_T:  t_reg[wb_ij]       <= wb.val;
                default:        ;
            endcase
        end
        if (cmd.out_load)
        begin
            out_fv  <= fv_reg;
            out_x0  <= x_reg[0];
            out_x1  <= x_reg[1];
            out_x2  <= x_reg[2];
            out_sat <= sat_reg;
        end
    end

endmodule

[rtl/scalar_kalman_filter_3state.sv]
// Top level of the three-state scalar-measurement Kalman filter.
// Depends on kfs_pkg, kfs_ctrl, kfs_dp (and kfs_div below it).

// One measurement beat in gives one result beat out. The shared 32x32
// multiply-accumulate unit walks 102 products in sequence (gain numerators,
// innovation variance, prediction, correction, filtered value and the
// covariance update F (P - G c P) F' + Q), with a drain after each of the
// ten matrix phases. The gain divider works through each of the three gain
// entries in turn (start, 32 quotient bits, done), and the S_ACC state adds
// the acceleration. The input is taken again once a step has finished; a
// finished result waits in the output register, and the next step runs
// meanwhile, holding its own result only until that beat leaves.
// Data is signed Q(31-FRAC_BITS).FRAC_BITS, coefficients Q4.12.
// Configuration writes are taken every cycle and must land while idle.
module scalar_kalman_filter_3state #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // measurement[31:0], acceleration[63:32]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // filtered_value, state_zero, state_one, state_two
    output logic         m_axis_tuser,   // saturated
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_data
);
    kfs_pkg::cmd_t  cmd;
    kfs_pkg::stat_t stat;
    logic signed [31:0] fv, x0, x1, x2;
    logic               sat;

    assign cfg_ready = 1'b1;

    kfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    kfs_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_meas   ($signed(s_axis_tdata[31:0])),
        .in_accel  ($signed(s_axis_tdata[63:32])),
        .cmd       (cmd),
        .stat      (stat),
        .out_fv    (fv),
        .out_x0    (x0),
        .out_x1    (x1),
        .out_x2    (x2),
        .out_sat   (sat)
    );

    assign m_axis_tdata = {x2, x1, x0, fv};
    assign m_axis_tuser = sat;

    // a step never accepts two beats back to back
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a step is running");

    // a new result only appears at the end of a running step
    a_result_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a step");

endmodule
